>>> sv/hpes_pkg.sv
`default_nettype none
package hpes_pkg;

	localparam int DIV_W = 30;
	localparam int CNT_W = 5;
	localparam int PC_W  = 5;

	typedef logic [PC_W-1:0] upc_t;

	localparam logic [7:0] GAIN_P_RST  = 8'd40;
	localparam logic [7:0] GAIN_I_RST  = 8'd9;
	localparam logic [7:0] GAIN_D_RST  = 8'd1;
	localparam logic [7:0] SP_STEP_RST = 8'd10;
	localparam logic [9:0] SP_MIN_RST  = 10'd0;
	localparam logic [9:0] SP_MAX_RST  = 10'd250;

	typedef enum logic [2:0] {
		REG_GAIN_P  = 3'd0,
		REG_GAIN_I  = 3'd1,
		REG_GAIN_D  = 3'd2,
		REG_SP_STEP = 3'd3,
		REG_SP_MIN  = 3'd4,
		REG_SP_MAX  = 3'd5
	} cfg_idx_t;

	typedef enum logic [4:0] {
		U_NOP    = 5'd0,
		U_LOAD   = 5'd1,
		U_E4     = 5'd2,
		U_MULP   = 5'd3,
		U_PSCALE = 5'd4,
		U_MULI   = 5'd5,
		U_INTEG  = 5'd6,
		U_ADDI   = 5'd7,
		U_MULD   = 5'd8,
		U_M250   = 5'd9,
		U_DINIT  = 5'd10,
		U_DSTEP  = 5'd11,
		U_DADD   = 5'd12,
		U_FIN    = 5'd13,
		U_OFF    = 5'd14,
		U_DET    = 5'd15,
		U_DETOUT = 5'd16
	} uop_t;

	typedef enum logic [2:0] {
		C_NONE   = 3'd0,
		C_NOACC  = 3'd1,
		C_DETENT = 3'd2,
		C_TZERO  = 3'd3,
		C_EBIG   = 3'd4,
		C_MSZERO = 3'd5,
		C_DMORE  = 3'd6,
		C_OBUSY  = 3'd7
	} cond_t;

	typedef struct packed {
		uop_t  uop;
		cond_t cond;
		logic  last;
		upc_t  addr;
	} uword_t;

	typedef struct packed {
		logic detent;
		logic tzero;
		logic ebig;
		logic mszero;
		logic dmore;
		logic obusy;
	} dp_stat_t;

	localparam upc_t A_IDLE     = 5'd0;
	localparam upc_t A_DISPATCH = 5'd1;
	localparam upc_t A_CHKZERO  = 5'd2;
	localparam upc_t A_E4       = 5'd3;
	localparam upc_t A_MULP     = 5'd4;
	localparam upc_t A_PSCALE   = 5'd5;
	localparam upc_t A_MULI     = 5'd6;
	localparam upc_t A_INTEG    = 5'd7;
	localparam upc_t A_ADDI     = 5'd8;
	localparam upc_t A_MULD     = 5'd9;
	localparam upc_t A_M250     = 5'd10;
	localparam upc_t A_DINIT    = 5'd11;
	localparam upc_t A_DSTEP    = 5'd12;
	localparam upc_t A_DADD     = 5'd13;
	localparam upc_t A_FIN      = 5'd14;
	localparam upc_t A_OFF      = 5'd15;
	localparam upc_t A_DET      = 5'd16;
	localparam upc_t A_DETOUT   = 5'd17;
	localparam upc_t A_LAST     = 5'd17;

	function automatic uword_t urom(input upc_t a);
		uword_t w;
		case (a)
			A_IDLE:     w = '{U_LOAD,   C_NOACC,  1'b0, A_IDLE};
			A_DISPATCH: w = '{U_NOP,    C_DETENT, 1'b0, A_DET};
			A_CHKZERO:  w = '{U_NOP,    C_TZERO,  1'b0, A_OFF};
			A_E4:       w = '{U_E4,     C_NONE,   1'b0, A_IDLE};
			A_MULP:     w = '{U_MULP,   C_NONE,   1'b0, A_IDLE};
			A_PSCALE:   w = '{U_PSCALE, C_EBIG,   1'b0, A_ADDI};
			A_MULI:     w = '{U_MULI,   C_NONE,   1'b0, A_IDLE};
			A_INTEG:    w = '{U_INTEG,  C_NONE,   1'b0, A_IDLE};
			A_ADDI:     w = '{U_ADDI,   C_NONE,   1'b0, A_IDLE};
			A_MULD:     w = '{U_MULD,   C_NONE,   1'b0, A_IDLE};
			A_M250:     w = '{U_M250,   C_MSZERO, 1'b0, A_FIN};
			A_DINIT:    w = '{U_DINIT,  C_NONE,   1'b0, A_IDLE};
			A_DSTEP:    w = '{U_DSTEP,  C_DMORE,  1'b0, A_DSTEP};
			A_DADD:     w = '{U_DADD,   C_NONE,   1'b0, A_IDLE};
			A_FIN:      w = '{U_FIN,    C_OBUSY,  1'b1, A_FIN};
			A_OFF:      w = '{U_OFF,    C_OBUSY,  1'b1, A_OFF};
			A_DET:      w = '{U_DET,    C_NONE,   1'b0, A_IDLE};
			A_DETOUT:   w = '{U_DETOUT, C_OBUSY,  1'b1, A_DETOUT};
			default:    w = '{U_NOP,    C_NONE,   1'b1, A_IDLE};
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

>>> sv/hpes_useq.sv
`default_nettype none
module hpes_useq (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     in_valid,
	input  hpes_pkg::dp_stat_t      stat,
	output hpes_pkg::uop_t          uop,
	output logic                    idle
);

	hpes_pkg::upc_t   pc_q;
	hpes_pkg::uword_t w;
	logic             taken;

	assign w    = hpes_pkg::urom(pc_q);
	assign uop  = w.uop;
	assign idle = (pc_q == hpes_pkg::A_IDLE);

	always_comb begin
		case (w.cond)
			hpes_pkg::C_NONE:   taken = 1'b0;
			hpes_pkg::C_NOACC:  taken = !in_valid;
			hpes_pkg::C_DETENT: taken = stat.detent;
			hpes_pkg::C_TZERO:  taken = stat.tzero;
			hpes_pkg::C_EBIG:   taken = stat.ebig;
			hpes_pkg::C_MSZERO: taken = stat.mszero;
			hpes_pkg::C_DMORE:  taken = stat.dmore;
			hpes_pkg::C_OBUSY:  taken = stat.obusy;
			default:            taken = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= hpes_pkg::A_IDLE;
		end else if (taken) begin
			pc_q <= w.addr;
		end else if (w.last) begin
			pc_q <= hpes_pkg::A_IDLE;
		end else begin
			pc_q <= pc_q + 1'b1;
		end
	end

	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q <= hpes_pkg::A_LAST)
		else $error("step counter out of program");

	a_accept_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q == hpes_pkg::A_IDLE && in_valid) |=> pc_q == hpes_pkg::A_DISPATCH)
		else $error("accepted word not dispatched");

	a_div_loop: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q == hpes_pkg::A_DSTEP && stat.dmore) |=> pc_q == hpes_pkg::A_DSTEP)
		else $error("divider loop left early");

endmodule
`default_nettype wire

>>> sv/hpes_dp.sv
`default_nettype none
module hpes_dp (
	input  wire                  clk,
	input  wire                  arst_n,
	input  hpes_pkg::uop_t       uop,
	input  wire                  cfg_we,
	input  wire  [2:0]           cfg_index,
	input  wire  [9:0]           cfg_data,
	input  wire                  op,
	input  wire                  direction,
	input  wire  [11:0]          temp_quarter,
	input  wire  [15:0]          elapsed_ms,
	input  wire                  out_stall,
	output logic                 out_valid,
	output logic [7:0]           drive_level,
	output logic [7:0]           drive_value,
	output logic                 heater_enabled,
	output logic [9:0]           target_degrees,
	output hpes_pkg::dp_stat_t   stat
);

	logic [7:0] gain_p_q, gain_i_q, gain_d_q, sp_step_q;
	logic [9:0] sp_min_q, sp_max_q;

	logic [9:0]         target_q;
	logic signed [15:0] integ_q;
	logic signed [13:0] prior_q;
	logic [7:0]         last_q;

	logic               op_q, dir_q;
	logic [11:0]        temp_q;
	logic [15:0]        ms_q;
	logic signed [13:0] e4_q;
	logic signed [14:0] de_q;
	logic signed [31:0] prod_q, acc_q;
	logic [15:0]        rem_q;
	logic [hpes_pkg::DIV_W-1:0] quo_q;
	logic               neg_q;
	logic [hpes_pkg::CNT_W-1:0] cnt_q;

	logic               out_valid_q, heater_enabled_q;
	logic [7:0]         drive_level_q, drive_value_q;
	logic [9:0]         target_degrees_q;

	logic signed [13:0] e4_c;
	logic signed [14:0] de_c;
	logic signed [8:0]  ma;
	logic signed [14:0] mb;
	logic signed [23:0] mprod;
	logic signed [32:0] m250;
	logic signed [31:0] isum, iq, mag, dq;
	logic signed [15:0] isat;
	logic [16:0]        sh, diff;
	logic               ge;
	logic [7:0]         clampv;
	logic [10:0]        up, lo;
	logic               out_free, emit;

	function automatic logic signed [31:0] q4(input logic signed [31:0] x);
		logic signed [31:0] b;
		b = x[31] ? 32'sd3 : 32'sd0;
		return (x + b) >>> 2;
	endfunction

	assign e4_c = $signed({2'b00, target_q, 2'b00}) - $signed({2'b00, temp_q});
	assign de_c = $signed({e4_c[13], e4_c}) - $signed({prior_q[13], prior_q});

	always_comb begin
		case (uop)
			hpes_pkg::U_MULP: begin
				ma = $signed({1'b0, gain_p_q});
				mb = $signed({e4_q[13], e4_q});
			end
			hpes_pkg::U_MULI: begin
				ma = $signed({1'b0, gain_i_q});
				mb = $signed({e4_q[13], e4_q});
			end
			hpes_pkg::U_MULD: begin
				ma = $signed({1'b0, gain_d_q});
				mb = de_q;
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	assign mprod = ma * mb;
	assign m250  = $signed(prod_q[23:0]) * $signed(9'sd250);

	assign isum = $signed({{14{integ_q[15]}}, integ_q, 2'b00}) + prod_q;
	assign iq   = q4(isum);
	always_comb begin
		if (iq > 32'sd32767) begin
			isat = 16'sh7FFF;
		end else if (iq < -32'sd32768) begin
			isat = 16'sh8000;
		end else begin
			isat = iq[15:0];
		end
	end

	assign mag  = prod_q[31] ? -prod_q : prod_q;
	assign sh   = {rem_q, quo_q[hpes_pkg::DIV_W-1]};
	assign diff = sh - {1'b0, ms_q};
	assign ge   = (sh >= {1'b0, ms_q});
	assign dq   = neg_q ? -$signed({{(32-hpes_pkg::DIV_W){1'b0}}, quo_q})
	                    : $signed({{(32-hpes_pkg::DIV_W){1'b0}}, quo_q});

	always_comb begin
		if (acc_q < 32'sd0) begin
			clampv = 8'd0;
		end else if (acc_q > 32'sd255) begin
			clampv = 8'd255;
		end else begin
			clampv = acc_q[7:0];
		end
	end

	assign up = {1'b0, target_q} + {3'b000, sp_step_q};
	assign lo = {1'b0, sp_min_q} + {3'b000, sp_step_q};

	assign out_free = !out_valid_q || !out_stall;
	assign emit = out_free && (uop == hpes_pkg::U_FIN || uop == hpes_pkg::U_OFF ||
		uop == hpes_pkg::U_DETOUT);

	// config and loop state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q    <= hpes_pkg::GAIN_P_RST;
			gain_i_q    <= hpes_pkg::GAIN_I_RST;
			gain_d_q    <= hpes_pkg::GAIN_D_RST;
			sp_step_q   <= hpes_pkg::SP_STEP_RST;
			sp_min_q    <= hpes_pkg::SP_MIN_RST;
			sp_max_q    <= hpes_pkg::SP_MAX_RST;
			target_q    <= '0;
			integ_q     <= '0;
			prior_q     <= '0;
			last_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					hpes_pkg::REG_GAIN_P:  gain_p_q  <= cfg_data[7:0];
					hpes_pkg::REG_GAIN_I:  gain_i_q  <= cfg_data[7:0];
					hpes_pkg::REG_GAIN_D:  gain_d_q  <= cfg_data[7:0];
					hpes_pkg::REG_SP_STEP: sp_step_q <= cfg_data[7:0];
					hpes_pkg::REG_SP_MIN:  sp_min_q  <= cfg_data;
					hpes_pkg::REG_SP_MAX:  sp_max_q  <= cfg_data;
					default: ;
				endcase
			end
			case (uop)
				hpes_pkg::U_INTEG: integ_q <= isat;
				hpes_pkg::U_DET: begin
					if (dir_q) begin
						if (up <= {1'b0, sp_max_q}) target_q <= up[9:0];
					end else begin
						if ({1'b0, target_q} >= lo) target_q <= target_q - {2'b00, sp_step_q};
					end
				end
				hpes_pkg::U_FIN: begin
					if (out_free) begin
						last_q  <= clampv;
						prior_q <= e4_q;
					end
				end
				hpes_pkg::U_OFF: begin
					if (out_free) last_q <= '0;
				end
				hpes_pkg::U_DETOUT: begin
					if (out_free && target_q == '0) last_q <= '0;
				end
				default: ;
			endcase
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working registers and result word
	always_ff @(posedge clk) begin
		case (uop)
			hpes_pkg::U_LOAD: begin
				op_q   <= op;
				dir_q  <= direction;
				temp_q <= temp_quarter;
				ms_q   <= elapsed_ms;
			end
			hpes_pkg::U_E4: begin
				e4_q <= e4_c;
				de_q <= de_c;
			end
			hpes_pkg::U_MULP, hpes_pkg::U_MULI, hpes_pkg::U_MULD: begin
				prod_q <= {{8{mprod[23]}}, mprod};
			end
			hpes_pkg::U_PSCALE: acc_q <= q4(prod_q);
			hpes_pkg::U_ADDI:   acc_q <= acc_q + {{16{integ_q[15]}}, integ_q};
			hpes_pkg::U_M250:   prod_q <= m250[31:0];
			hpes_pkg::U_DINIT: begin
				neg_q <= prod_q[31];
				quo_q <= mag[hpes_pkg::DIV_W-1:0];
				rem_q <= '0;
				cnt_q <= hpes_pkg::CNT_W'(hpes_pkg::DIV_W - 1);
			end
			hpes_pkg::U_DSTEP: begin
				rem_q <= ge ? diff[15:0] : sh[15:0];
				quo_q <= {quo_q[hpes_pkg::DIV_W-2:0], ge};
				if (cnt_q != '0) cnt_q <= cnt_q - 1'b1;
			end
			hpes_pkg::U_DADD: acc_q <= acc_q + dq;
			default: ;
		endcase
		if (emit) begin
			target_degrees_q <= target_q;
			case (uop)
				hpes_pkg::U_FIN: begin
					drive_value_q    <= clampv;
					drive_level_q    <= ~clampv;
					heater_enabled_q <= 1'b1;
				end
				hpes_pkg::U_DETOUT: begin
					drive_value_q    <= (target_q == '0) ? 8'd0 : last_q;
					drive_level_q    <= (target_q == '0) ? 8'hFF : ~last_q;
					heater_enabled_q <= (target_q != '0);
				end
				default: begin
					drive_value_q    <= 8'd0;
					drive_level_q    <= 8'hFF;
					heater_enabled_q <= 1'b0;
				end
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign drive_level    = drive_level_q;
	assign drive_value    = drive_value_q;
	assign heater_enabled = heater_enabled_q;
	assign target_degrees = target_degrees_q;

	assign stat.detent = !op_q;
	assign stat.tzero  = (target_q == '0);
	assign stat.ebig   = !(e4_q > -14'sd12 && e4_q < 14'sd12);
	assign stat.mszero = (ms_q == '0);
	assign stat.dmore  = (cnt_q != '0);
	assign stat.obusy  = !out_free;

	a_enabled_target: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && heater_enabled_q) |-> target_degrees_q != '0)
		else $error("heater enabled with zero target");

	a_off_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !heater_enabled_q) |-> drive_value_q == '0)
		else $error("drive nonzero while heater off");

	a_level_inv: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> drive_level_q == ~drive_value_q)
		else $error("level is not inverted drive");

endmodule
`default_nettype wire

>>> sv/heater_pid_with_encoder_setpoint.sv
// Heater PID controller with encoder-set target temperature.
// Input channel (in_valid/in_stall): op 0 is an encoder detent that moves
// the setpoint by setpoint_step within setpoint_min..setpoint_max; op 1 is a
// control update with a quarter-degree temperature and elapsed milliseconds.
// Every input word gives exactly one output word (out_valid/out_stall):
// drive level (255 = off), clamped drive, enable flag and current setpoint.
// Config channel (cfg_valid/cfg_ready, always ready): cfg_index 0..5 picks
// gain_p, gain_i, gain_d, setpoint_step, setpoint_min, setpoint_max; others
// are dropped. Write config only while idle.
// One word at a time, run by a microcode sequencer. A control update runs
// the sequencer steps and a 30-bit bit-serial divider for the derivative
// term; it skips the integrator update when the error is outside the
// integrator window, goes straight to an off output with zero setpoint, and
// skips the divider with zero elapsed time. The next word is taken once the
// result is loaded and the sequencer is back at idle; in_stall stays high until then.
// A stalled receiver holds the output word; the sequencer waits at its last
// step until the output register frees up.
// Reset: setpoint, integrator, prior error and held drive clear to zero,
// gains and limits load their defaults, output goes invalid.
`default_nettype none
module heater_pid_with_encoder_setpoint (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire         op,
	input  wire         direction,
	input  wire  [11:0] temp_quarter,
	input  wire  [15:0] elapsed_ms,
	output logic        out_valid,
	input  wire         out_stall,
	output logic [7:0]  drive_level,
	output logic [7:0]  drive_value,
	output logic        heater_enabled,
	output logic [9:0]  target_degrees,
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [2:0]  cfg_index,
	input  wire  [9:0]  cfg_data
);

	hpes_pkg::uop_t     uop;
	hpes_pkg::dp_stat_t stat;
	logic               idle;

	assign in_stall  = !idle;
	assign cfg_ready = 1'b1;

	hpes_useq u_useq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.stat     (stat),
		.uop      (uop),
		.idle     (idle)
	);

	hpes_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.uop            (uop),
		.cfg_we         (cfg_valid),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.op             (op),
		.direction      (direction),
		.temp_quarter   (temp_quarter),
		.elapsed_ms     (elapsed_ms),
		.out_stall      (out_stall),
		.out_valid      (out_valid),
		.drive_level    (drive_level),
		.drive_value    (drive_value),
		.heater_enabled (heater_enabled),
		.target_degrees (target_degrees),
		.stat           (stat)
	);

endmodule
`default_nettype wire
